>>> sv/iss_pkg.sv
// shared types and constants for the indexed sequence store
package iss_pkg;

    localparam int CAPACITY_DEFAULT      = 16;
    localparam int ELEMENT_WIDTH_DEFAULT = 32;
    localparam int POS_W                 = 5;
    localparam int DATA_W                = 32;
    localparam int COUNT_W               = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [POS_W-1:0]    position;
        logic [DATA_W-1:0]   element_in;
    } in_word_t;

    typedef struct packed {
        logic                ok;
        logic [DATA_W-1:0]   element_out;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } out_word_t;

    typedef struct packed {
        logic                ins_en;
        logic                rem_en;
        logic [POS_W-1:0]    position;
    } cell_ctrl_t;

endpackage

>>> sv/iss_cell.sv
// one storage cell of the sequence chain, shifts with its neighbors
module iss_cell #(
    parameter int INDEX         = 0,
    parameter int ELEMENT_WIDTH = iss_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  iss_pkg::cell_ctrl_t      ctrl,
    input  logic [ELEMENT_WIDTH-1:0] new_data,
    input  logic [ELEMENT_WIDTH-1:0] left_data,
    input  logic [ELEMENT_WIDTH-1:0] right_data,
    output logic [ELEMENT_WIDTH-1:0] data
);

    logic [ELEMENT_WIDTH-1:0] entry_reg;
    logic [ELEMENT_WIDTH-1:0] entry_next;
    logic                     hit;
    logic                     above;
    logic                     at_or_above;

    assign hit         = (int'(ctrl.position) == INDEX);
    assign above       = (int'(ctrl.position) < INDEX);
    assign at_or_above = hit || above;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.ins_en && hit)
        begin
            entry_next = new_data;
        end
        else if (ctrl.ins_en && above)
        begin
            entry_next = left_data;
        end
        else if (ctrl.rem_en && at_or_above)
        begin
            entry_next = right_data;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

>>> sv/indexed_sequence_store_unit.sv
// top level of the indexed sequence store: control, count and cell chain
//
// usage:
//   input channel in_valid / in_stall / in_word carries one request word:
//   opcode (insert, remove, get, clear), position and element_in.
//   output channel out_valid / out_stall / out_word returns exactly one
//   result word per request: ok, element_out, count and is_empty.
//   each result is registered and shows on out_word in the cycle after
//   acceptance, and a new request is taken each cycle while the output
//   is free or being taken. the rate is set by the cell chain, where every
//   cell compares its own index with the position and shifts from a
//   neighbor in the same cycle.
//   reset clears the count and the output valid; entry contents stay
//   undefined until inserted and are never read before that.
//   while out_valid is high and out_stall is high the result word holds and
//   in_stall is raised, so no request is taken until the result is taken.
module indexed_sequence_store_unit #(
    parameter int CAPACITY      = iss_pkg::CAPACITY_DEFAULT,
    parameter int ELEMENT_WIDTH = iss_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  iss_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output iss_pkg::out_word_t out_word
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    iss_pkg::out_word_t       out_word_reg;
    iss_pkg::out_word_t       out_word_next;

    logic                     accept;
    logic [CMPW-1:0]          pos_ext;
    logic [CMPW-1:0]          cnt_ext;
    logic                     not_full;
    logic                     ins_ok;
    logic                     idx_ok;
    logic                     op_ok;
    iss_pkg::cell_ctrl_t      ctrl;
    logic [ELEMENT_WIDTH-1:0] din;
    logic [ELEMENT_WIDTH-1:0] rd_data;
    logic [iss_pkg::DATA_W-1:0] rd_word;
    logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign pos_ext  = CMPW'(in_word.position);
    assign cnt_ext  = CMPW'(count_reg);
    assign not_full = (count_reg < CW'(CAPACITY));
    assign ins_ok   = (pos_ext <= cnt_ext) && not_full;
    assign idx_ok   = (pos_ext < cnt_ext);

    always_comb
    begin
        din = '0;
        for (int b = 0; b < ELEMENT_WIDTH && b < iss_pkg::DATA_W; b++)
        begin
            din[b] = in_word.element_in[b];
        end
    end

    always_comb
    begin
        ctrl.ins_en   = accept && (in_word.opcode == iss_pkg::OP_INSERT) && ins_ok;
        ctrl.rem_en   = accept && (in_word.opcode == iss_pkg::OP_REMOVE) && idx_ok;
        ctrl.position = in_word.position;
    end

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_data;
        logic [ELEMENT_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = din;
        end
        else
        begin : g_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_right
            assign right_data = cell_data[i+1];
        end

        iss_cell #(
            .INDEX         (i),
            .ELEMENT_WIDTH (ELEMENT_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_data   (din),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    // one-hot read across the cells
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (int'(in_word.position) == i)
            begin
                rd_data = rd_data | cell_data[i];
            end
        end
    end

    always_comb
    begin
        rd_word = '0;
        for (int b = 0; b < ELEMENT_WIDTH && b < iss_pkg::DATA_W; b++)
        begin
            rd_word[b] = rd_data[b];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        op_ok      = 1'b0;
        unique case (in_word.opcode)
            iss_pkg::OP_INSERT:
            begin
                op_ok = ins_ok;
                if (ins_ok)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            iss_pkg::OP_REMOVE:
            begin
                op_ok = idx_ok;
                if (idx_ok)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            iss_pkg::OP_GET:
            begin
                op_ok = idx_ok;
            end
            iss_pkg::OP_CLEAR:
            begin
                op_ok      = 1'b1;
                count_next = '0;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_word_next.ok          = op_ok;
        out_word_next.element_out = (in_word.opcode == iss_pkg::OP_GET && idx_ok)
                                    ? rd_word : '0;
        out_word_next.count       = iss_pkg::COUNT_W'(count_next);
        out_word_next.is_empty    = (count_next == '0);
        out_valid_next            = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count above capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_word.opcode == iss_pkg::OP_CLEAR |=> count_reg == '0)
        else $error("clear did not empty the store");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_word_reg.ok |-> out_word_reg.element_out == '0)
        else $error("failed word carries data");
`endif

endmodule
